// ----- hw/rtl/qrs_pkg.sv -----
// qrs_pkg: shared types and root-count codes for the quadratic root solver.
// No dependencies.
package qrs_pkg;

  typedef struct packed {
    logic en;
    logic vld;
  } qrs_ctl_t;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

endpackage

// ----- hw/rtl/qrs_disc.sv -----
// qrs_disc: three-stage discriminant unit, d = b^2 - 4ac from magnitudes and the sign of ac.
// Products are split into half-width partial products. Depends on qrs_pkg.
module qrs_disc import qrs_pkg::*; #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  qrs_ctl_t         ctl,
  input  logic [W-1:0]     ma,
  input  logic [W-1:0]     mb,
  input  logic [W-1:0]     mc,
  input  logic             sgn_diff,
  input  logic [SW-1:0]    side_in,
  output logic             vld_out,
  output logic [2*W+2:0]   d,
  output logic             dneg,
  output logic [SW-1:0]    side_out
);

  localparam int H  = (W + 1) / 2;
  localparam int HW = W - H;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 3;

  logic [H-1:0]      bl, al, cl;
  logic [HW-1:0]     bh, ah, ch;
  logic [2*H-1:0]    bb_ll_nxt, ac_ll_nxt, bb_ll_r, ac_ll_r;
  logic [H+HW-1:0]   bb_lh_nxt, ac_lh_nxt, ac_hl_nxt, bb_lh_r, ac_lh_r, ac_hl_r;
  logic [2*HW-1:0]   bb_hh_nxt, ac_hh_nxt, bb_hh_r, ac_hh_r;
  logic              sd1_r, sd2_r;
  logic [SW-1:0]     side1_r, side2_r, side3_r;
  logic [2:0]        vld_r;
  logic [PW-1:0]     b2_nxt, ac_nxt, b2_r, ac_r;
  logic [DW-1:0]     b2e, ac4e, d_nxt, d_r;
  logic              dneg_nxt, dneg_r;

  assign bl = mb[H-1:0];
  assign bh = mb[W-1:H];
  assign al = ma[H-1:0];
  assign ah = ma[W-1:H];
  assign cl = mc[H-1:0];
  assign ch = mc[W-1:H];

  assign bb_ll_nxt = bl * bl;
  assign bb_lh_nxt = bl * bh;
  assign bb_hh_nxt = bh * bh;
  assign ac_ll_nxt = al * cl;
  assign ac_lh_nxt = al * ch;
  assign ac_hl_nxt = ah * cl;
  assign ac_hh_nxt = ah * ch;

  assign b2_nxt = (PW'(bb_hh_r) << (2 * H)) + (PW'(bb_lh_r) << (H + 1)) + PW'(bb_ll_r);
  assign ac_nxt = (PW'(ac_hh_r) << (2 * H)) + (PW'(ac_lh_r) << H) + (PW'(ac_hl_r) << H)
                + PW'(ac_ll_r);

  assign b2e  = DW'(b2_r);
  assign ac4e = DW'(ac_r) << 2;

  always_comb begin
    dneg_nxt = 1'b0;
    if (sd2_r) begin
      d_nxt = b2e + ac4e;
    end else if (b2e >= ac4e) begin
      d_nxt = b2e - ac4e;
    end else begin
      d_nxt    = '0;
      dneg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[1:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      bb_ll_r <= bb_ll_nxt;
      bb_lh_r <= bb_lh_nxt;
      bb_hh_r <= bb_hh_nxt;
      ac_ll_r <= ac_ll_nxt;
      ac_lh_r <= ac_lh_nxt;
      ac_hl_r <= ac_hl_nxt;
      ac_hh_r <= ac_hh_nxt;
      sd1_r   <= sgn_diff;
      side1_r <= side_in;
      b2_r    <= b2_nxt;
      ac_r    <= ac_nxt;
      sd2_r   <= sd1_r;
      side2_r <= side1_r;
      d_r     <= d_nxt;
      dneg_r  <= dneg_nxt;
      side3_r <= side2_r;
    end
  end

  assign vld_out  = vld_r[2];
  assign d        = d_r;
  assign dneg     = dneg_r;
  assign side_out = side3_r;

endmodule

// ----- hw/rtl/qrs_sqrt.sv -----
// qrs_sqrt: pipelined floor square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  qrs_ctl_t        ctl,
  input  logic [2*W+2:0]  d,
  input  logic [SW-1:0]   side_in,
  output logic            vld_out,
  output logic [W+1:0]    root,
  output logic [SW-1:0]   side_out
);

  localparam int RB = W + 2;
  localparam int DW = 2 * W + 3;
  localparam int TW = 2 * RB + 1;

  logic [DW-1:0] rem_r    [RB];
  logic [RB-1:0] root_r   [RB];
  logic [SW-1:0] side_r   [RB];
  logic [DW-1:0] rem_nxt  [RB];
  logic [RB-1:0] root_nxt [RB];
  logic [RB-1:0] vld_r;

  for (genvar j = 0; j < RB; j++) begin : g_stage
    localparam int K = RB - 1 - j;
    logic [DW-1:0] rem_in;
    logic [RB-1:0] root_in;
    logic [TW-1:0] trial;
    logic          fits;
    if (j == 0) begin : g_first
      assign rem_in  = d;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end
    assign trial       = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
    assign fits        = TW'(rem_in) >= trial;
    assign rem_nxt[j]  = fits ? DW'(TW'(rem_in) - trial) : rem_in;
    assign root_nxt[j] = fits ? (root_in | (RB'(1) << K)) : root_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[RB-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int j = 0; j < RB; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        side_r[j] <= (j == 0) ? side_in : side_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign vld_out  = vld_r[RB-1];
  assign root     = root_r[RB-1];
  assign side_out = side_r[RB-1];

endmodule

// ----- hw/rtl/qrs_div.sv -----
// qrs_div: pipelined signed fixed-point divider, (num << F) / den, one
// quotient bit per stage after the first, saturated to the W-bit range. Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  qrs_ctl_t        ctl,
  input  logic [W+2:0]    num,
  input  logic [W:0]      den,
  input  logic            neg,
  input  logic [SW-1:0]   side_in,
  output logic            vld_out,
  output logic [W-1:0]    quo,
  output logic            sat,
  output logic [SW-1:0]   side_out
);

  localparam int NW   = W + 3;
  localparam int DENW = W + 1;
  localparam int NF   = NW + F;
  localparam int CW   = NF + W + 2;
  localparam int NS   = W + 1;

  logic [NF-1:0]   rem_r    [NS];
  logic [W-1:0]    q_r      [NS];
  logic [DENW-1:0] den_r    [NS];
  logic [SW-1:0]   side_r   [NS];
  logic [NF-1:0]   rem_nxt  [NS];
  logic [W-1:0]    q_nxt    [NS];
  logic [NS-1:0]   big_r, neg_r, vld_r;
  logic [NF-1:0]   n_shift;
  logic            big_nxt;
  logic [W-1:0]    lim, mag_q;

  assign n_shift = NF'(num) << F;
  assign big_nxt = CW'(n_shift) >= (CW'(den) << W);
  assign rem_nxt[0] = n_shift;
  assign q_nxt[0]   = '0;

  for (genvar j = 1; j < NS; j++) begin : g_stage
    localparam int K = W - j;
    logic [CW-1:0] sub;
    logic          fits;
    assign sub        = CW'(den_r[j-1]) << K;
    assign fits       = CW'(rem_r[j-1]) >= sub;
    assign rem_nxt[j] = fits ? NF'(CW'(rem_r[j-1]) - sub) : rem_r[j-1];
    assign q_nxt[j]   = fits ? (q_r[j-1] | (W'(1) << K)) : q_r[j-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[NS-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      big_r <= {big_r[NS-2:0], big_nxt};
      neg_r <= {neg_r[NS-2:0], neg};
      for (int j = 0; j < NS; j++) begin
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
        den_r[j]  <= (j == 0) ? den : den_r[(j == 0) ? 0 : j - 1];
        side_r[j] <= (j == 0) ? side_in : side_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign lim      = neg_r[NS-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign sat      = big_r[NS-1] | (q_r[NS-1] > lim);
  assign mag_q    = sat ? lim : q_r[NS-1];
  assign quo      = neg_r[NS-1] ? -mag_q : mag_q;
  assign vld_out  = vld_r[NS-1];
  assign side_out = side_r[NS-1];

endmodule

// ----- hw/rtl/quadratic_root_solver.sv -----
// Quadratic root solver: input register, 3-stage discriminant, (W+2)-stage square
// root, numerator register, two (W+1)-stage dividers, output register.
// Throughput one transaction per cycle unless a stall while out_valid is high freezes
// the whole pipeline. Synchronous active-low reset clears all valid bits and sets
// tol_r to 1. Depends on qrs_pkg and submodules.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COEFF_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COEFF_WIDTH-1:0] in_coef_square,
  input  logic signed [COEFF_WIDTH-1:0] in_coef_linear,
  input  logic signed [COEFF_WIDTH-1:0] in_coef_constant,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_root_count,
  output logic signed [COEFF_WIDTH-1:0] out_first_root,
  output logic signed [COEFF_WIDTH-1:0] out_second_root,
  output logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [15:0]                   cfg_wr_data
);

  localparam int W   = COEFF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * W + 3;
  localparam int RB  = W + 2;
  localparam int SWD = 6 + 3 * W;
  localparam int SWS = 6 + 3 * W;

  logic           en;
  logic [15:0]    tol_r, tol_eff;
  logic           vld1_r;
  logic [W-1:0]   ma1_r, mb1_r, mc1_r;
  logic           sa1_r, sb1_r, sc1_r;
  logic           za1, zb1, zc1;
  qrs_ctl_t       ctl_d, ctl_s, ctl_v;

  logic               vld_d;
  logic [DW-1:0]      d_d;
  logic               dneg_d;
  logic [SWD-1:0]     side_d;
  logic [1:0]         cnt_d;
  logic [DW-1:0]      thresh;

  logic               vld_s;
  logic [RB-1:0]      root_s;
  logic [SWS-1:0]     side_s;
  logic [1:0]         cnt_s;
  logic               za_s, sa_s, sb_s, sc_s;
  logic [W-1:0]       ma_s, mb_s, mc_s;
  logic [W+3:0]       negb, n1, n2;
  logic [W+2:0]       n1m, n2m;

  logic               vldp_r;
  logic [W+2:0]       numa_nxt, numa_r, numb_r;
  logic [W:0]         dena_nxt, dena_r, denb_r;
  logic               nega_nxt, nega_r, negb_r;
  logic [1:0]         cntp_r;

  logic               vld_qa, vld_qb;
  logic [W-1:0]       qa, qb;
  logic               sat_qa, sat_qb;
  logic [1:0]         cnt_q;
  logic               use2_q;

  logic               out_valid_r;
  logic [1:0]         cnt_out_r;
  logic [W-1:0]       r1_out_r, r2_out_r;
  logic               sat_out_r;
  logic               one_or_two;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign tol_eff  = (tol_r == '0) ? 16'd1 : tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd1;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // input register: magnitudes and signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa1_r <= in_coef_square[W-1];
      sb1_r <= in_coef_linear[W-1];
      sc1_r <= in_coef_constant[W-1];
      ma1_r <= in_coef_square[W-1] ? -in_coef_square : in_coef_square;
      mb1_r <= in_coef_linear[W-1] ? -in_coef_linear : in_coef_linear;
      mc1_r <= in_coef_constant[W-1] ? -in_coef_constant : in_coef_constant;
    end
  end

  assign za1 = ma1_r < W'(tol_eff);
  assign zb1 = mb1_r < W'(tol_eff);
  assign zc1 = mc1_r < W'(tol_eff);

  assign ctl_d = '{en: en, vld: vld1_r};

  qrs_disc #(.W(W), .SW(SWD)) u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_d),
    .ma       (ma1_r),
    .mb       (mb1_r),
    .mc       (mc1_r),
    .sgn_diff (sa1_r ^ sc1_r),
    .side_in  ({za1, zb1, zc1, sa1_r, sb1_r, sc1_r, ma1_r, mb1_r, mc1_r}),
    .vld_out  (vld_d),
    .d        (d_d),
    .dneg     (dneg_d),
    .side_out (side_d)
  );

  // root count from zero flags and discriminant
  assign thresh = DW'(tol_eff) << F;

  always_comb begin
    if (side_d[SWD-1]) begin
      if (side_d[SWD-2]) begin
        cnt_d = side_d[SWD-3] ? CNT_ALL : CNT_NONE;
      end else begin
        cnt_d = CNT_ONE;
      end
    end else if (dneg_d) begin
      cnt_d = CNT_NONE;
    end else if (d_d < thresh) begin
      cnt_d = CNT_ONE;
    end else begin
      cnt_d = CNT_TWO;
    end
  end

  assign ctl_s = '{en: en, vld: vld_d};

  qrs_sqrt #(.W(W), .SW(SWS)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_s),
    .d        (d_d),
    .side_in  ({cnt_d, side_d[SWD-1], side_d[3*W+2:0]}),
    .vld_out  (vld_s),
    .root     (root_s),
    .side_out (side_s)
  );

  assign cnt_s = side_s[SWS-1:SWS-2];
  assign za_s  = side_s[SWS-3];
  assign sa_s  = side_s[3*W+2];
  assign sb_s  = side_s[3*W+1];
  assign sc_s  = side_s[3*W];
  assign ma_s  = side_s[3*W-1:2*W];
  assign mb_s  = side_s[2*W-1:W];
  assign mc_s  = side_s[W-1:0];

  assign negb = sb_s ? (W+4)'(mb_s) : -((W+4)'(mb_s));
  assign n1   = negb - (W+4)'(root_s);
  assign n2   = negb + (W+4)'(root_s);
  assign n1m  = n1[W+3] ? (W+3)'(-n1) : n1[W+2:0];
  assign n2m  = n2[W+3] ? (W+3)'(-n2) : n2[W+2:0];

  always_comb begin
    if (za_s) begin
      numa_nxt = (W+3)'(mc_s);
      dena_nxt = (W+1)'(mb_s);
      nega_nxt = (sc_s == sb_s);
    end else if (cnt_s == CNT_ONE) begin
      numa_nxt = (W+3)'(mb_s);
      dena_nxt = {ma_s, 1'b0};
      nega_nxt = (sb_s == sa_s);
    end else begin
      numa_nxt = n1m;
      dena_nxt = {ma_s, 1'b0};
      nega_nxt = n1[W+3] ^ sa_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldp_r <= 1'b0;
    end else if (en) begin
      vldp_r <= vld_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numa_r <= numa_nxt;
      dena_r <= dena_nxt;
      nega_r <= nega_nxt;
      numb_r <= n2m;
      denb_r <= {ma_s, 1'b0};
      negb_r <= n2[W+3] ^ sa_s;
      cntp_r <= cnt_s;
    end
  end

  assign ctl_v = '{en: en, vld: vldp_r};

  qrs_div #(.W(W), .F(F), .SW(2)) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_v),
    .num      (numa_r),
    .den      (dena_r),
    .neg      (nega_r),
    .side_in  (cntp_r),
    .vld_out  (vld_qa),
    .quo      (qa),
    .sat      (sat_qa),
    .side_out (cnt_q)
  );

  qrs_div #(.W(W), .F(F), .SW(1)) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_v),
    .num      (numb_r),
    .den      (denb_r),
    .neg      (negb_r),
    .side_in  (cntp_r == CNT_TWO),
    .vld_out  (vld_qb),
    .quo      (qb),
    .sat      (sat_qb),
    .side_out (use2_q)
  );

  assign one_or_two = (cnt_q == CNT_ONE) || (cnt_q == CNT_TWO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_qa;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_out_r <= cnt_q;
      r1_out_r  <= one_or_two ? qa : '0;
      r2_out_r  <= use2_q ? qb : '0;
      sat_out_r <= (one_or_two & sat_qa) | (use2_q & sat_qb);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_count  = cnt_out_r;
  assign out_first_root  = r1_out_r;
  assign out_second_root = r2_out_r;
  assign out_saturated   = sat_out_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    vld_qa == vld_qb)
    else $error("divider lanes out of step");

  a_no_root_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_count == CNT_NONE || out_root_count == CNT_ALL)
    |-> out_first_root == '0 && out_second_root == '0 && !out_saturated)
    else $error("root data on a rootless transaction");

  a_second_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count != CNT_TWO |-> out_second_root == '0)
    else $error("second root without two roots");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ----- test/quadratic_root_solver_tb.sv -----
// Testbench for quadratic_root_solver: drives coefficient transactions with random
// gaps and output stalls, predicts roots bit-exactly and compares every field.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * W + 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1510;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [1:0]         root_count;
    logic signed [W-1:0] first_root;
    logic signed [W-1:0] second_root;
    logic               saturated;
  } roots_t;

  typedef struct {
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [W-1:0] c;
    logic                typed;
    roots_t              want;
  } coef_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [W-1:0] in_coef_square, in_coef_linear, in_coef_constant;
  logic out_valid, out_stall;
  logic [1:0] out_root_count;
  logic signed [W-1:0] out_first_root, out_second_root;
  logic out_saturated;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  roots_t expected_roots[$];
  logic [15:0] tolerance;
  int errors = 0;
  int idle_cycles = 0;
  bit sending_done = 0;
  bit hold_off = 0;
  coef_row_t directed[DIRECTED_ROWS];

  quadratic_root_solver uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coef_square(in_coef_square), .in_coef_linear(in_coef_linear),
    .in_coef_constant(in_coef_constant),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_root_count(out_root_count), .out_first_root(out_first_root),
    .out_second_root(out_second_root), .out_saturated(out_saturated),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(logic signed [W-1:0] v);
    logic signed [63:0] x;
    x = v;
    return x < 0 ? -x : x;
  endfunction

  function automatic logic [W-1:0] sat_quotient(bit neg, logic [63:0] num, logic [63:0] den,
                                                inout logic sat);
    logic [127:0] q;
    logic [63:0] lim;
    q = ({64'd0, num} << FB) / den;
    lim = neg ? (64'd1 << (W - 1)) : (64'd1 << (W - 1)) - 1;
    if (q > lim) begin
      q = lim;
      sat = 1;
    end
    return neg ? -q[W-1:0] : q[W-1:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] d);
    logic [63:0] r, t;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= d) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                         logic signed [W-1:0] c);
    roots_t r;
    logic [63:0] tol, ma, mb, mc, den, s;
    logic [127:0] b2, ac4, d;
    logic signed [63:0] n1, n2;
    logic sat;
    r = '0;
    sat = 0;
    tol = tolerance == 0 ? 1 : tolerance;
    ma = magnitude(a);
    mb = magnitude(b);
    mc = magnitude(c);
    if (ma < tol) begin
      if (mb < tol) begin
        r.root_count = mc < tol ? CNT_ALL : CNT_NONE;
      end else begin
        r.root_count = CNT_ONE;
        r.first_root = sat_quotient((c < 0) == (b < 0), mc, mb, sat);
      end
    end else begin
      b2 = {64'd0, mb} * {64'd0, mb};
      ac4 = ({64'd0, ma} * {64'd0, mc}) << 2;
      den = ma << 1;
      if ((a < 0) == (c < 0) && b2 < ac4) begin
        r.root_count = CNT_NONE;
      end else begin
        d = ((a < 0) != (c < 0)) ? b2 + ac4 : b2 - ac4;
        if (d < ({64'd0, tol} << FB)) begin
          r.root_count = CNT_ONE;
          r.first_root = sat_quotient((b < 0) == (a < 0), mb, den, sat);
        end else begin
          s = floor_sqrt(d);
          n1 = -64'(b) - $signed(s);
          n2 = -64'(b) + $signed(s);
          r.root_count = CNT_TWO;
          r.first_root = sat_quotient((n1 < 0) != (a < 0), n1 < 0 ? -n1 : n1, den, sat);
          r.second_root = sat_quotient((n2 < 0) != (a < 0), n2 < 0 ? -n2 : n2, den, sat);
        end
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_coefs(logic signed [W-1:0] a, logic signed [W-1:0] b,
                            logic signed [W-1:0] c, bit wait_gap);
    int gap;
    gap = wait_gap ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_coef_square <= a;
    in_coef_linear <= b;
    in_coef_constant <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_roots.push_back(solve_roots(a, b, c));
    @(negedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    in_valid <= 0;
    while (expected_roots.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    tolerance = v;
  endtask

  function automatic logic signed [W-1:0] random_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 65535)) - 32768;
      2: return $signed($urandom_range(0, 32'h7FFFF)) - 32'h40000;
      3: return 32'sh7FFFFFFF - $urandom_range(0, 3);
      4: return 32'sh80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'hFFFFFF)) - 32'h800000;
    endcase
  endfunction

  task automatic run_random(int n);
    logic signed [W-1:0] a, b, c, r1, r2;
    for (int i = 0; i < n; i++) begin
      a = random_coef();
      b = random_coef();
      c = random_coef();
      case ($urandom_range(0, 5))
        0: a = $signed($urandom_range(0, 8)) - 4;
        1: begin
          a = $signed($urandom_range(0, 8)) - 4;
          b = $signed($urandom_range(0, 8)) - 4;
        end
        2: begin
          // near double root: b = -2*a*r, c = a*r^2 scaled
          a = $signed($urandom_range(1, 1024)) <<< 8;
          r1 = $signed($urandom_range(0, 255)) - 128;
          b = -2 * a * r1;
          c = a * r1 * r1;
        end
        3: begin
          r1 = $signed($urandom_range(0, 255)) - 128;
          r2 = $signed($urandom_range(0, 255)) - 128;
          a = 32'sh10000;
          b = -((r1 + r2) <<< 16);
          c = (r1 * r2) <<< 16;
        end
        default: ;
      endcase
      send_coefs(a, b, c, 1);
    end
  endtask

  always @(posedge clk) begin
    roots_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected result", out_root_count, 0);
      end else begin
        want = expected_roots.pop_front();
        if (out_root_count !== want.root_count)
          report_mismatch("root_count", out_root_count, want.root_count);
        if (out_first_root !== want.first_root)
          report_mismatch("first_root", out_first_root, want.first_root);
        if (out_second_root !== want.second_root)
          report_mismatch("second_root", out_second_root, want.second_root);
        if (out_saturated !== want.saturated)
          report_mismatch("saturated", out_saturated, want.saturated);
      end
    end
  end

  // receiver stalls
  initial begin
    int gap;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    directed[0]  = '{32'sd0, 32'sd0, 32'sd0, 1, '{CNT_ALL, 0, 0, 0}};
    directed[1]  = '{32'sd0, 32'sd0, 32'sh10000, 1, '{CNT_NONE, 0, 0, 0}};
    directed[2]  = '{32'sd0, 32'sh10000, -32'sh20000, 1, '{CNT_ONE, 32'sh20000, 0, 0}};
    directed[3]  = '{32'sd0, 32'sd1, 32'sh7FFFFFFF, 1, '{CNT_ONE, 32'sh80000000, 0, 1}};
    directed[4]  = '{32'sd0, -32'sd1, 32'sh7FFFFFFF, 1, '{CNT_ONE, 32'sh7FFFFFFF, 0, 1}};
    directed[5]  = '{32'sh10000, 32'sd0, 32'sh10000, 1, '{CNT_NONE, 0, 0, 0}};
    directed[6]  = '{32'sh10000, 32'sd0, -32'sh10000, 1,
                     '{CNT_TWO, -32'sh10000, 32'sh10000, 0}};
    directed[7]  = '{-32'sh10000, 32'sd0, 32'sh10000, 1,
                     '{CNT_TWO, 32'sh10000, -32'sh10000, 0}};
    directed[8]  = '{32'sh10000, -32'sh20000, 32'sh10000, 1, '{CNT_ONE, 32'sh10000, 0, 0}};
    directed[9]  = '{32'sh10000, 32'sd0, 32'sd1, 1, '{CNT_NONE, 0, 0, 0}};
    directed[10] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, '0};
    directed[11] = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, '0};
    directed[12] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 0, '0};
    directed[13] = '{32'sd1, 32'sh7FFFFFFF, 32'sd0, 0, '0};
    directed[14] = '{32'sd1, 32'sh80000000, 32'sh7FFFFFFF, 0, '0};
    directed[15] = '{-32'sd1, 32'sd0, 32'sh80000000, 0, '0};
    directed[16] = '{32'sh30000, 32'sh50000, -32'sh70000, 0, '0};
    directed[17] = '{32'sh10000, 32'sd3, 32'sd1, 0, '0};
    directed[18] = '{32'sh55555, -32'h12345, 32'sh777, 0, '0};
    directed[19] = '{-32'sh7, 32'sh1, 32'sh3, 0, '0};

    rst_n = 0;
    in_valid = 0;
    in_coef_square = 0;
    in_coef_linear = 0;
    in_coef_constant = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    tolerance = 16'd1;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_coefs(directed[i].a, directed[i].b, directed[i].c, 0);
      if (directed[i].typed && expected_roots[$] !== directed[i].want)
        report_mismatch("directed row table", i, 0);
    end

    // fill the pipeline against a held-off receiver
    hold_off = 1;
    for (int i = 0; i < 120; i++)
      send_coefs(random_coef(), random_coef(), random_coef(), 0);

    run_random(500);
    write_tolerance(16'd0);
    run_random(200);
    write_tolerance(16'hFFFF);
    run_random(200);
    write_tolerance(16'd300);
    run_random(300);
    write_tolerance(16'(~16'd300));
    run_random(150);
    write_tolerance(16'd1);
    run_random(RANDOM_ITEMS - 1350);
    in_valid <= 0;

    sending_done = 1;
    while (expected_roots.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_disc.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver.sv
test/quadratic_root_solver_tb.sv
